### src/lrsi_pkg.sv
// Package for the slope-intercept line rasterizer.
// Holds the item structs, command codes and controller/datapath link types.
// No dependencies.
package lrsi_pkg;

   localparam int CoordBits = 12;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [CoordBits-1:0] start_x;
      logic [CoordBits-1:0] start_y;
      logic [CoordBits-1:0] end_x;
      logic [CoordBits-1:0] end_y;
   } req_item_type;

   typedef struct packed {
      logic [CoordBits-1:0] pixel_x;
      logic [CoordBits-1:0] pixel_y;
      logic                 last_pixel;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

### src/lrsi_ctrl.sv
// Controller for the line rasterizer: line state, handshakes, output valid.
// Depends on lrsi_pkg; drives lrsi_datapath through ctl_cmd_type.
module lrsi_ctrl
   import lrsi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctl_cmd_type   ctl_cmd,
   input  dp_status_type dp_status
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_ACTIVE = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl_cmd      = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) begin
         if (req_cmd == CMD_LOAD) begin
            ctl_cmd.load = 1'b1;
            state_in     = ST_ACTIVE;
         end else begin
            unique case (state_ff)
               ST_ACTIVE: begin
                  ctl_cmd.emit = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (dp_status.last) begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/lrsi_datapath.sv
// Datapath for the line rasterizer: endpoint setup, error-term stepping, pixel register.
// Depends on lrsi_pkg; commanded by lrsi_ctrl.
module lrsi_datapath
   import lrsi_pkg::*;
(
   input  logic          clock,
   input  req_item_type  req_item,
   input  ctl_cmd_type   ctl_cmd,
   output dp_status_type dp_status,
   output rsp_item_type  rsp_item
);

   localparam int C = CoordBits;

   logic                y_major_ff, y_major_in;
   logic [C-1:0]        major_pos_ff, major_pos_in;
   logic [C-1:0]        major_stop_ff, major_stop_in;
   logic [C-1:0]        major_delta_ff, major_delta_in;
   logic [C-1:0]        minor_pos_ff, minor_pos_in;
   logic signed [C:0]   minor_delta_ff, minor_delta_in;
   logic [C:0]          rem_ff, rem_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic signed [C:0]   dx, dy, adx_w, ady_w, md_new;
   logic [C-1:0]        adx, ady;
   logic                y_major_new, swap;
   logic [C-1:0]        ma0, ma1, mi0, mi1;
   logic [C-1:0]        lo_ma, hi_ma, lo_mi, hi_mi;
   logic signed [C+2:0] r_sum, two_d;
   logic                last;

   assign last           = (major_pos_ff == major_stop_ff);
   assign dp_status.last = last;
   assign rsp_item       = rsp_ff;

   always_comb begin
      dx    = $signed({1'b0, req_item.end_x}) - $signed({1'b0, req_item.start_x});
      dy    = $signed({1'b0, req_item.end_y}) - $signed({1'b0, req_item.start_y});
      adx_w = dx[C] ? -dx : dx;
      ady_w = dy[C] ? -dy : dy;
      adx   = adx_w[C-1:0];
      ady   = ady_w[C-1:0];
      y_major_new = (ady > adx) || (dx == '0);
      if (y_major_new) begin
         ma0 = req_item.start_y;
         ma1 = req_item.end_y;
         mi0 = req_item.start_x;
         mi1 = req_item.end_x;
      end else begin
         ma0 = req_item.start_x;
         ma1 = req_item.end_x;
         mi0 = req_item.start_y;
         mi1 = req_item.end_y;
      end
      swap  = ma0 > ma1;
      lo_ma = swap ? ma1 : ma0;
      hi_ma = swap ? ma0 : ma1;
      lo_mi = swap ? mi1 : mi0;
      hi_mi = swap ? mi0 : mi1;
      md_new = $signed({1'b0, hi_mi}) - $signed({1'b0, lo_mi});
   end

   always_comb begin
      y_major_in     = y_major_ff;
      major_pos_in   = major_pos_ff;
      major_stop_in  = major_stop_ff;
      major_delta_in = major_delta_ff;
      minor_pos_in   = minor_pos_ff;
      minor_delta_in = minor_delta_ff;
      rem_in         = rem_ff;
      rsp_in         = rsp_ff;
      r_sum = $signed({2'b00, rem_ff}) + $signed({minor_delta_ff[C], minor_delta_ff, 1'b0});
      two_d = $signed({2'b00, major_delta_ff, 1'b0});
      if (ctl_cmd.load) begin
         y_major_in     = y_major_new;
         major_pos_in   = lo_ma;
         major_stop_in  = hi_ma;
         major_delta_in = hi_ma - lo_ma;
         minor_pos_in   = lo_mi;
         minor_delta_in = md_new;
         rem_in         = {1'b0, hi_ma - lo_ma};
      end else if (ctl_cmd.emit) begin
         rsp_in.pixel_x    = y_major_ff ? minor_pos_ff : major_pos_ff;
         rsp_in.pixel_y    = y_major_ff ? major_pos_ff : minor_pos_ff;
         rsp_in.last_pixel = last;
         major_pos_in      = major_pos_ff + 1'b1;
         priority if (r_sum >= two_d) begin
            rem_in       = (C+1)'(r_sum - two_d);
            minor_pos_in = minor_pos_ff + 1'b1;
         end else if (r_sum < 0) begin
            rem_in       = (C+1)'(r_sum + two_d);
            minor_pos_in = minor_pos_ff - 1'b1;
         end else begin
            rem_in = (C+1)'(r_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      y_major_ff     <= y_major_in;
      major_pos_ff   <= major_pos_in;
      major_stop_ff  <= major_stop_in;
      major_delta_ff <= major_delta_in;
      minor_pos_ff   <= minor_pos_in;
      minor_delta_ff <= minor_delta_in;
      rem_ff         <= rem_in;
      rsp_ff         <= rsp_in;
   end

endmodule

### src/line_rasterizer_slope_intercept_top.sv
// Slope-intercept line rasterizer, top level.
// Takes one item per cycle while req_stall is low; a pixel appears on rsp in the cycle after its advance item.
// An error term steps the minor axis.
// Reset (synchronous) drops any line in progress and clears the pending pixel.
// Depends on lrsi_pkg, lrsi_ctrl and lrsi_datapath.
module line_rasterizer_slope_intercept_top
   import lrsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   lrsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_item.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status)
   );

   lrsi_datapath u_datapath (
      .clock     (clock),
      .req_item  (req_item),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status),
      .rsp_item  (rsp_item)
   );

endmodule
